// ===== sv/bbc_pkg.sv =====
package bbc_pkg;

  localparam int SECTIONS    = 4;
  localparam int SAMPLE_BITS = 24;

  localparam int COEF_W    = 32;
  localparam int COEF_FRAC = 28;
  localparam int OPND_W    = SAMPLE_BITS + 1;
  localparam int PROD_W    = COEF_W + OPND_W;
  localparam int ACC_W     = PROD_W + 3;
  localparam int Q_W       = ACC_W - COEF_FRAC;
  localparam int SEC_W     = (SECTIONS > 1) ? $clog2(SECTIONS) : 1;
  localparam int NUM_TAPS  = 4;
  localparam int NUM_RATES = 4;
  localparam int NUM_MODES = 2;

  localparam int RATE_W      = 2;
  localparam int MODE_W      = 1;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 2;

  localparam logic [CFG_INDEX_W-1:0] REG_RATE_SELECT = CFG_INDEX_W'(0);
  localparam logic [CFG_INDEX_W-1:0] REG_FILTER_MODE = CFG_INDEX_W'(1);

  localparam longint unsigned ONE_Q30      = 64'd1 << 30;
  localparam longint unsigned PI_Q30       = 64'd3373259426;
  localparam longint unsigned CUTOFF_HZ    = 64'd20000;
  localparam int              SERIES_TERMS = 15;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic signed [COEF_W-1:0]      coef_t;
  typedef logic signed [OPND_W-1:0]      opnd_t;

  // Coefficient order inside one section.
  typedef enum logic [1:0] {
    TAP_B0,
    TAP_B1,
    TAP_A1,
    TAP_A2
  } tap_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MAC,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic acc_en;
    logic acc_first;
  } mac_ctl_t;

  typedef coef_t     [NUM_TAPS-1:0]  tap_set_t;
  typedef tap_set_t  [SECTIONS-1:0]  sec_set_t;
  typedef sec_set_t  [NUM_MODES-1:0] mode_set_t;
  typedef mode_set_t [NUM_RATES-1:0] coef_rom_t;

  // Unsigned truncating quotient by restoring long division; table building only.
  function automatic longint unsigned quot_u64(longint unsigned n, longint unsigned d);
    longint unsigned q;
    logic [64:0]     r;
    q = '0;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      r = {r[63:0], n[b]};
      if (r >= {1'b0, d}) begin
        r    = r - {1'b0, d};
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // Taylor series in unsigned Q2.30; odd selects sine, else cosine.
  function automatic longint unsigned series_q30(longint unsigned x, bit odd);
    longint unsigned term;
    longint unsigned m;
    longint          sum;
    term = odd ? x : ONE_Q30;
    m    = odd ? 64'd2 : 64'd1;
    sum  = longint'(term);
    for (int i = 1; i < SERIES_TERMS; i++) begin
      term = quot_u64((((term * x) >> 30) * x) >> 30, m * (m + 64'd1));
      m    = m + 64'd2;
      if ((i % 2) == 1) begin
        sum = sum - longint'(term);
      end else begin
        sum = sum + longint'(term);
      end
    end
    if (sum < 0) begin
      sum = 0;
    end
    if (sum > longint'(ONE_Q30)) begin
      sum = longint'(ONE_Q30);
    end
    return unsigned'(sum);
  endfunction

  // Elaboration-time coefficient table for every rate code and mode.
  function automatic coef_rom_t build_coef_rom();
    coef_rom_t       rom;
    longint unsigned fs;
    longint unsigned wc;
    longint unsigned s;
    longint unsigned c;
    longint unsigned th;
    longint unsigned sk;
    longint unsigned den;
    longint unsigned num;
    longint unsigned order;
    longint          v;
    rom   = '0;
    order = 64'd2 * 64'(SECTIONS) + 64'd1;
    for (int r = 0; r < NUM_RATES; r++) begin
      fs = (r == 0) ? 64'd96000 : ((r == 1) ? 64'd192000 : 64'd384000);
      wc = quot_u64(PI_Q30 * 64'd2 * CUTOFF_HZ, fs);
      s  = series_q30(wc, 1'b1);
      c  = series_q30(wc, 1'b0);
      for (int k = 0; k < SECTIONS; k++) begin
        th  = quot_u64(PI_Q30 * (64'd2 * 64'(k) + 64'd1), 64'd2 * order);
        sk  = (s * series_q30(th, 1'b1)) >> 30;
        den = ONE_Q30 + sk;
        for (int md = 0; md < NUM_MODES; md++) begin
          v = longint'(quot_u64(((64'd2 * c) << COEF_FRAC) + den / 64'd2, den));
          rom[r][md][k][TAP_A1] = COEF_W'(v);
          v = longint'(quot_u64(((ONE_Q30 - sk) << COEF_FRAC) + den / 64'd2, den));
          rom[r][md][k][TAP_A2] = COEF_W'(-v);
          num = (md == 0) ? (ONE_Q30 - c) : (ONE_Q30 + c);
          v = longint'(quot_u64((num << COEF_FRAC) + den / 64'd2, den));
          rom[r][md][k][TAP_B1] = (md == 0) ? COEF_W'(v) : COEF_W'(-v);
          v = longint'(quot_u64((num << (COEF_FRAC - 1)) + den / 64'd2, den));
          rom[r][md][k][TAP_B0] = COEF_W'(v);
        end
      end
    end
    return rom;
  endfunction

  localparam coef_rom_t COEF_ROM = build_coef_rom();

endpackage

// ===== sv/bbc_mac.sv =====
module bbc_mac (
  input  logic             clk,
  input  bbc_pkg::mac_ctl_t ctl,
  input  bbc_pkg::coef_t   coef,
  input  bbc_pkg::opnd_t   operand,
  output bbc_pkg::sample_t y
);
  import bbc_pkg::*;

  localparam logic signed [Q_W-1:0] Q_HI = Q_W'((64'd1 << (SAMPLE_BITS - 1)) - 64'd1);
  localparam logic signed [Q_W-1:0] Q_LO = -(Q_W'(64'd1 << (SAMPLE_BITS - 1)));
  localparam logic signed [ACC_W-1:0] HALF_LSB = ACC_W'(64'd1 << (COEF_FRAC - 1));

  logic signed [PROD_W-1:0] prod;
  logic signed [ACC_W-1:0]  acc;
  logic signed [ACC_W-1:0]  total;
  logic signed [ACC_W-1:0]  rounded;
  logic signed [Q_W-1:0]    q;

  // Product register splits the multiplier from the accumulate add.
  always_ff @(posedge clk) begin
    prod <= coef * operand;
    if (ctl.acc_en) begin
      acc <= (ctl.acc_first ? '0 : acc) + ACC_W'(prod);
    end
  end

  // Fold in the last product, round half up, saturate.
  always_comb begin
    total   = acc + ACC_W'(prod);
    rounded = total + HALF_LSB;
    q       = $signed(rounded[ACC_W-1:COEF_FRAC]);
    if (q > Q_HI) begin
      y = SAMPLE_BITS'(Q_HI);
    end else if (q < Q_LO) begin
      y = SAMPLE_BITS'(Q_LO);
    end else begin
      y = SAMPLE_BITS'(q);
    end
  end

endmodule

// ===== sv/butterworth_biquad_cascade_unit.sv =====
// Butterworth biquad cascade: each request carries one signed Q1.23 sample
// that runs through SECTIONS direct-form-I biquads in series, each section
// saturated to 24 bits; the result is the last section's output. The
// coefficients (Q4.28, 20 kHz cutoff) come from a constant table selected by
// rate_select (0 = 96 kHz, 1 = 192 kHz, 2 and 3 = 384 kHz) and filter_mode
// (0 = low-pass, 1 = high-pass); write those only while the block is idle.
// The delay stores keep their contents across register writes and clear on
// reset. One shared multiply-accumulate unit does all the work: per section
// it steps through the taps b0, b1, a1 and a2 in state MAC, then rounds and
// saturates in state FINISH; a new request is taken only once the block
// has returned to IDLE after the last section. A finished result waits in the
// output register while the next sample is processed; only the final write of
// a new result stalls if the previous one was not yet taken.
module butterworth_biquad_cascade_unit (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write,
  input  logic [bbc_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [bbc_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [bbc_pkg::SAMPLE_BITS-1:0] sample_in,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [bbc_pkg::SAMPLE_BITS-1:0] sample_out
);
  import bbc_pkg::*;

  state_t           state;
  state_t           state_next;
  logic [SEC_W-1:0] sec;
  tap_t             tap;
  tap_t             tap_next;
  sample_t          x_cur;

  // Per-section delay stores: x1, x2, y1, y2.
  sample_t xd1 [SECTIONS];
  sample_t xd2 [SECTIONS];
  sample_t yd1 [SECTIONS];
  sample_t yd2 [SECTIONS];

  logic [RATE_W-1:0] rate_select;
  logic [MODE_W-1:0] filter_mode;

  mac_ctl_t mac_ctl;
  coef_t    coef;
  opnd_t    operand;
  sample_t  sec_y;
  logic     last_sec;
  logic     can_finish;
  logic     finish_go;

  assign last_sec   = (sec == SEC_W'(SECTIONS - 1));
  // Hold the final write while the previous result is still unclaimed.
  assign can_finish = !last_sec || !out_valid || out_ready;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      rate_select <= '0;
      filter_mode <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_RATE_SELECT: rate_select <= cfg_data[RATE_W-1:0];
        REG_FILTER_MODE: filter_mode <= cfg_data[MODE_W-1:0];
        default: ;
      endcase
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = ST_MAC;
        end
      end
      ST_MAC: begin
        if (tap == TAP_A2) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (can_finish) begin
          state_next = last_sec ? ST_IDLE : ST_MAC;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    in_ready          = (state == ST_IDLE);
    mac_ctl.acc_en    = (state == ST_MAC) && (tap != TAP_B0);
    mac_ctl.acc_first = (tap == TAP_B1);
    finish_go         = (state == ST_FINISH) && can_finish;
    unique case (tap)
      TAP_B0:  tap_next = TAP_B1;
      TAP_B1:  tap_next = TAP_A1;
      TAP_A1:  tap_next = TAP_A2;
      TAP_A2:  tap_next = TAP_A2;
      default: tap_next = TAP_B0;
    endcase
  end

  // Coefficient and operand for the current tap.
  always_comb begin
    coef = COEF_ROM[rate_select][filter_mode][sec][tap];
    unique case (tap)
      TAP_B0:  operand = OPND_W'(x_cur) + OPND_W'(xd2[sec]);
      TAP_B1:  operand = OPND_W'(xd1[sec]);
      TAP_A1:  operand = OPND_W'(yd1[sec]);
      TAP_A2:  operand = OPND_W'(yd2[sec]);
      default: operand = '0;
    endcase
  end

  bbc_mac u_mac (
    .clk     (clk),
    .ctl     (mac_ctl),
    .coef    (coef),
    .operand (operand),
    .y       (sec_y)
  );

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      sec       <= '0;
      tap       <= TAP_B0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (in_valid && in_ready) begin
        sec <= '0;
        tap <= TAP_B0;
      end else if (state == ST_MAC) begin
        tap <= tap_next;
      end else if (finish_go) begin
        tap <= TAP_B0;
        if (!last_sec) begin
          sec <= sec + SEC_W'(1);
        end
      end
      if (finish_go && last_sec) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Working sample and result register.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      x_cur <= sample_in;
    end else if (finish_go) begin
      x_cur <= sec_y;
    end
    if (finish_go && last_sec) begin
      sample_out <= sec_y;
    end
  end

  // Delay stores: advance the current section once its output is known.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < SECTIONS; i++) begin
        xd1[i] <= '0;
        xd2[i] <= '0;
        yd1[i] <= '0;
        yd2[i] <= '0;
      end
    end else if (finish_go) begin
      xd2[sec] <= xd1[sec];
      xd1[sec] <= x_cur;
      yd2[sec] <= yd1[sec];
      yd1[sec] <= sec_y;
    end
  end

`ifndef SYNTHESIS
  a_sec_range: assert property (@(posedge clk) disable iff (rst)
    int'(sec) < SECTIONS)
    else $error("section index out of range");

  a_finish_tap: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FINISH) |-> (tap == TAP_A2))
    else $error("finish reached before last tap");

  a_accept_start: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (state == ST_MAC && sec == '0 && tap == TAP_B0))
    else $error("accepted sample did not start at first section");

  a_finish_stall: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FINISH && !can_finish) |=> (state == ST_FINISH && $stable(sec)
      && out_valid))
    else $error("final write did not hold for a pending result");

  a_section_step: assert property (@(posedge clk) disable iff (rst)
    (finish_go && !last_sec) |=> (state == ST_MAC && sec == $past(sec) + SEC_W'(1)))
    else $error("section did not advance after finish");
`endif

endmodule

// ===== tb/butterworth_biquad_cascade_unit_test.sv =====
// Self-checking bench for the Butterworth biquad cascade unit. A bit-true
// predictor of the four-section direct-form-I chain runs alongside the block:
// it builds its own Q4.28 coefficient set for the selected sample rate and
// filter mode and keeps its own delay stores. Each accepted sample request is
// pushed through that predictor, and the filtered value is queued. Each
// accepted output request is checked against the oldest queued value.
module butterworth_biquad_cascade_unit_test;
  import bbc_pkg::*;

  // Register values.
  localparam logic [CFG_DATA_W-1:0] RATE_96K      = CFG_DATA_W'(0);
  localparam logic [CFG_DATA_W-1:0] RATE_192K     = CFG_DATA_W'(1);
  localparam logic [CFG_DATA_W-1:0] RATE_384K     = CFG_DATA_W'(2);
  localparam logic [CFG_DATA_W-1:0] RATE_SPARE    = CFG_DATA_W'(3);
  localparam logic [CFG_DATA_W-1:0] MODE_LOWPASS  = CFG_DATA_W'(0);
  localparam logic [CFG_DATA_W-1:0] MODE_HIGHPASS = CFG_DATA_W'(1);

  // Register indexes the block does not decode; writes there must be ignored.
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_A = CFG_INDEX_W'(2);
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_B = CFG_INDEX_W'(3);

  localparam sample_t FULL_POS = sample_t'((1 << (SAMPLE_BITS - 1)) - 1);
  localparam sample_t FULL_NEG = sample_t'(-(1 << (SAMPLE_BITS - 1)));
  localparam longint  ROUND_HALF = longint'(1) << (COEF_FRAC - 1);

  localparam int WATCHDOG_LIMIT = 2000;
  // Give stray outputs time to show.
  localparam int SETTLE_CYCLES  = 8 * SECTIONS + 10;
  localparam int MAX_REPORTS    = 10;

  typedef enum int {SEG_NOISE, SEG_SQUARE, SEG_RAMP, SEG_QUIET} segment_kind_t;

  logic    clk       = 1'b0;
  logic    rst       = 1'b1;
  logic    cfg_write = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = REG_RATE_SELECT;
  logic [CFG_DATA_W-1:0]  cfg_data  = '0;
  logic    in_valid  = 1'b0;
  logic    in_ready;
  sample_t sample_in = '0;
  logic    out_valid;
  logic    out_ready = 1'b0;
  sample_t sample_out;

  // Predictor state: selected registers, coefficients and per-section delays.
  logic [RATE_W-1:0] rate_reg;
  logic [MODE_W-1:0] mode_reg;
  longint tap_b0[SECTIONS];
  longint tap_b1[SECTIONS];
  longint tap_a1[SECTIONS];
  longint tap_a2[SECTIONS];
  longint x_prev1[SECTIONS];
  longint x_prev2[SECTIONS];
  longint y_prev1[SECTIONS];
  longint y_prev2[SECTIONS];

  sample_t filtered_queue[$];
  int      mismatch_count = 0;
  int      samples_sent   = 0;
  bit      source_gaps_on = 1'b1;
  bit      sink_stalls_on = 1'b1;

  butterworth_biquad_cascade_unit uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .sample_in (sample_in),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sample_out(sample_out)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // ---------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------

  // Unsigned Q2.30 Taylor series, 15 terms, each product truncated; clamp
  // the sum into [0, 1].
  function automatic longint unsigned taylor_q30(longint unsigned angle, bit want_sine);
    longint unsigned part;
    longint unsigned fact;
    longint          total;
    part  = want_sine ? angle : ONE_Q30;
    fact  = want_sine ? 64'd2 : 64'd1;
    total = longint'(part);
    for (int n = 1; n < SERIES_TERMS; n++) begin
      part = ((((part * angle) >> 30) * angle) >> 30) / (fact * (fact + 64'd1));
      fact = fact + 64'd2;
      total = (n % 2 == 1) ? total - longint'(part) : total + longint'(part);
    end
    if (total < 0) total = 0;
    if (total > longint'(ONE_Q30)) total = longint'(ONE_Q30);
    return unsigned'(total);
  endfunction

  // Rounded quotient num/den in the given number of fraction bits.
  function automatic longint q_ratio(longint unsigned num, longint unsigned den, int frac);
    return longint'(((num << frac) + den / 64'd2) / den);
  endfunction

  // Rebuild the coefficient set for the current rate and mode.
  function automatic void load_coefficients();
    longint unsigned fs;
    longint unsigned wc;
    longint unsigned sin_wc;
    longint unsigned cos_wc;
    longint unsigned half_order;
    longint unsigned theta;
    longint unsigned damp;
    longint unsigned den;
    case (rate_reg)
      RATE_96K:  fs = 64'd96000;
      RATE_192K: fs = 64'd192000;
      default:   fs = 64'd384000;  // spare rate code runs as 384 kHz
    endcase
    wc         = PI_Q30 * 64'd2 * CUTOFF_HZ / fs;
    sin_wc     = taylor_q30(wc, 1'b1);
    cos_wc     = taylor_q30(wc, 1'b0);
    half_order = 64'd2 * (64'd2 * 64'(SECTIONS) + 64'd1);
    for (int k = 0; k < SECTIONS; k++) begin
      theta     = PI_Q30 * (64'd2 * 64'(k) + 64'd1) / half_order;
      damp      = (sin_wc * taylor_q30(theta, 1'b1)) >> 30;
      den       = ONE_Q30 + damp;
      tap_a1[k] = q_ratio(64'd2 * cos_wc, den, COEF_FRAC);
      tap_a2[k] = -q_ratio(ONE_Q30 - damp, den, COEF_FRAC);
      if (mode_reg == MODE_W'(MODE_LOWPASS)) begin
        tap_b1[k] = q_ratio(ONE_Q30 - cos_wc, den, COEF_FRAC);
        tap_b0[k] = q_ratio(ONE_Q30 - cos_wc, den, COEF_FRAC - 1);
      end else begin
        tap_b1[k] = -q_ratio(ONE_Q30 + cos_wc, den, COEF_FRAC);
        tap_b0[k] = q_ratio(ONE_Q30 + cos_wc, den, COEF_FRAC - 1);
      end
    end
  endfunction

  function automatic void reset_predictor();
    for (int k = 0; k < SECTIONS; k++) begin
      x_prev1[k] = 0;
      x_prev2[k] = 0;
      y_prev1[k] = 0;
      y_prev2[k] = 0;
    end
    rate_reg = '0;
    mode_reg = '0;
    load_coefficients();
  endfunction

  // Push one sample through every section; round half up, saturate, shift
  // the delays.
  function automatic sample_t run_cascade(sample_t s);
    longint x;
    longint acc;
    longint y;
    x = longint'(s);
    for (int k = 0; k < SECTIONS; k++) begin
      acc = tap_b0[k] * (x + x_prev2[k]) + tap_b1[k] * x_prev1[k]
          + tap_a1[k] * y_prev1[k] + tap_a2[k] * y_prev2[k];
      y = (acc + ROUND_HALF) >>> COEF_FRAC;
      if (y > longint'(FULL_POS)) y = longint'(FULL_POS);
      if (y < longint'(FULL_NEG)) y = longint'(FULL_NEG);
      x_prev2[k] = x_prev1[k];
      x_prev1[k] = x;
      y_prev2[k] = y_prev1[k];
      y_prev1[k] = y;
      x = y;
    end
    return sample_t'(x);
  endfunction

  // ---------------------------------------------------------------------
  // Output side: random back-pressure and result checking
  // ---------------------------------------------------------------------

  // Hold out_ready low for random-length bursts while stalls are on.
  initial begin
    int burst;
    forever begin
      @(posedge clk);
      if (sink_stalls_on && $urandom_range(0, 3) == 0) begin
        burst = $urandom_range(1, 10);
        out_ready <= 1'b0;
        repeat (burst) @(posedge clk);
      end
      out_ready <= 1'b1;
    end
  end

  // Compare each accepted result with the oldest prediction.
  initial begin
    sample_t want;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && out_ready) begin
        if (filtered_queue.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS)
            $display("unexpected output request: sample_out %0d", sample_out);
        end else begin
          want = filtered_queue.pop_front();
          if (sample_out !== want) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
              $display("sample_out mismatch: expected %0d, got %0d", want, sample_out);
          end
        end
      end
    end
  end

  // Watchdog: end the run if no request moves on either side for too long.
  initial begin
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("watchdog: no request accepted for %0d cycles", WATCHDOG_LIMIT);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // ---------------------------------------------------------------------
  // Input side
  // ---------------------------------------------------------------------

  // Offer one sample and hold it until accepted, then predict its result.
  // Valid is left high; the caller either sends again or drops valid.
  task automatic send_sample(input sample_t s);
    in_valid  <= 1'b1;
    sample_in <= s;
    do @(posedge clk); while (!in_ready);
    filtered_queue.push_back(run_cascade(s));
    samples_sent++;
  endtask

  task automatic idle_source(input int cycles);
    in_valid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // Send, then maybe idle for a random burst.
  task automatic feed_sample(input sample_t s);
    send_sample(s);
    if (source_gaps_on && $urandom_range(0, 3) == 0)
      idle_source($urandom_range(1, 10));
  endtask

  // Drop valid and hold off until every predicted result has come back.
  task automatic wait_for_drain();
    in_valid <= 1'b0;
    while (filtered_queue.size() != 0) @(posedge clk);
  endtask

  // Drive one register write; the write lands at the next edge. The enable
  // stays high so that writes can run back to back.
  task automatic write_register(input logic [CFG_INDEX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    case (idx)
      REG_RATE_SELECT: begin
        rate_reg = RATE_W'(val);
        load_coefficients();
      end
      REG_FILTER_MODE: begin
        mode_reg = MODE_W'(val);
        load_coefficients();
      end
      default: begin
      end
    endcase
  endtask

  // Wait until idle, then set rate and mode; optionally poke an unused index
  // with random data in between.
  task automatic program_filter(input logic [CFG_DATA_W-1:0] rate,
                                input logic [CFG_DATA_W-1:0] mode,
                                input bit poke_spare);
    wait_for_drain();
    write_register(REG_RATE_SELECT, rate);
    if (poke_spare)
      write_register($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B,
                     CFG_DATA_W'($urandom));
    write_register(REG_FILTER_MODE, mode);
    cfg_write <= 1'b0;
  endtask

  // One stretch of random stimulus: noise, square wave (full scale at times,
  // driving the sections into saturation), ramp, or near-silence.
  task automatic run_segment();
    segment_kind_t kind;
    int      len;
    int      period;
    int      step;
    sample_t level;
    sample_t s;
    kind   = segment_kind_t'($urandom_range(0, 3));
    len    = $urandom_range(8, 40);
    period = $urandom_range(1, 12);
    step   = $urandom_range(1, 1 << 16) - (1 << 15);
    level  = $urandom_range(0, 1) ? FULL_POS : sample_t'($urandom);
    for (int n = 0; n < len; n++) begin
      case (kind)
        SEG_NOISE:  s = sample_t'($urandom);
        SEG_SQUARE: s = ((n / period) % 2 == 0) ? level : ~level;
        SEG_RAMP:   s = sample_t'(int'(level) + n * step);
        default:    s = sample_t'(int'($urandom_range(0, 63)) - 32);
      endcase
      feed_sample(s);
    end
  endtask

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------

  // Reset settings (96 kHz low-pass): full-scale steps, zero, smallest
  // values, an impulse and a full-scale alternation.
  task automatic test_extremes();
    feed_sample(FULL_POS);
    feed_sample(FULL_POS);
    feed_sample(FULL_POS);
    feed_sample(FULL_NEG);
    feed_sample(FULL_NEG);
    feed_sample('0);
    feed_sample(sample_t'(1));
    feed_sample(sample_t'(-1));
    feed_sample('0);
    feed_sample(FULL_NEG);
    feed_sample(FULL_POS);
    feed_sample(FULL_NEG);
  endtask

  // Every rate code, the spare one included, in both modes; unused indexes
  // are written on the way and must change nothing. The delays carry over.
  task automatic test_register_sweep();
    logic [CFG_DATA_W-1:0] rates[4];
    rates = '{RATE_96K, RATE_192K, RATE_384K, RATE_SPARE};
    for (int r = 0; r < 4; r++) begin
      program_filter(rates[r], MODE_LOWPASS, 1'b1);
      feed_sample(FULL_POS);
      program_filter(rates[r], MODE_HIGHPASS, 1'b1);
      feed_sample(FULL_NEG);
    end
  endtask

  // Short bursts, each followed by a full drain before the next one.
  task automatic test_drain_pause();
    program_filter(RATE_192K, MODE_HIGHPASS, 1'b0);
    for (int b = 0; b < 5; b++) begin
      repeat (8) feed_sample(sample_t'($urandom));
      wait_for_drain();
    end
  endtask

  // Main random body: phases with fresh settings, gaps and stalls on both sides.
  task automatic test_random_phases();
    int target;
    for (int p = 0; p < 12; p++) begin
      program_filter(CFG_DATA_W'(p % 4), $urandom_range(0, 1) ? MODE_HIGHPASS : MODE_LOWPASS,
                     $urandom_range(0, 3) == 0);
      target = samples_sent + 118;
      while (samples_sent < target) run_segment();
    end
  endtask

  // Last part: no idling on either side, samples back to back.
  task automatic test_back_to_back();
    program_filter(RATE_384K, MODE_HIGHPASS, 1'b0);
    source_gaps_on = 1'b0;
    sink_stalls_on = 1'b0;
    repeat (125) feed_sample(sample_t'($urandom));
    program_filter(RATE_96K, MODE_LOWPASS, 1'b0);
    repeat (125) feed_sample($urandom_range(0, 1) ? FULL_POS : FULL_NEG);
  endtask

  initial begin
    reset_predictor();
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    test_extremes();
    test_register_sweep();
    test_drain_pause();
    test_random_phases();
    test_back_to_back();
    wait_for_drain();
    // Leave room for any stray output before judging.
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && filtered_queue.size() == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
